### design/tcp_reno_sender_window_model_top_defines.svh
// Assertion macros used by the checker file of the sender window model.
`ifndef TCP_RENO_SENDER_WINDOW_MODEL_TOP_DEFINES_SVH
`define TCP_RENO_SENDER_WINDOW_MODEL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define TRSW_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define TRSW_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/trsw_pkg.sv
`default_nettype none

package trsw_pkg;

	// Default number of packets in one transfer.
	localparam int PACKET_COUNT_DEF = 128;

	// Register reset values.
	localparam logic [15:0] INIT_WINDOW_RST    = 16'd4;
	localparam logic [15:0] INIT_THRESHOLD_RST = 16'd16;
	localparam logic        VARIANT_RST        = 1'b0;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_INIT_WINDOW    = 2'd0;
	localparam logic [1:0] REG_INIT_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_VARIANT        = 2'd2;

	// Variant codes.
	localparam logic VARIANT_RENO    = 1'b0;
	localparam logic VARIANT_NEWRENO = 1'b1;

	// Event codes reported with each result.
	typedef enum logic [2:0] {
		EV_CONTINUE      = 3'd0,
		EV_SLOW_START    = 3'd1,
		EV_AVOIDANCE     = 3'd2,
		EV_FAST_RECOVERY = 3'd3,
		EV_TIMEOUT       = 3'd4,
		EV_FINISHED      = 3'd5
	} ev_t;

	// One result beat.
	typedef struct packed {
		logic [7:0]  sent_packet;
		logic [7:0]  cumulative_ack;
		logic [2:0]  event_res;
		logic [15:0] window;
		logic [15:0] threshold;
		logic [7:0]  next_packet;
		logic        finished;
		logic [15:0] sent_total;
	} res_t;

	// Status of the ack scanner toward the sequencer.
	typedef struct packed {
		logic clearing;
		logic done;
	} scan_stat_t;

endpackage

`default_nettype wire

### design/trsw_ackscan.sv
`default_nettype none

module trsw_ackscan #(
	parameter int PACKET_COUNT = trsw_pkg::PACKET_COUNT_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire  [$clog2(PACKET_COUNT)-1:0]      mark_addr,
	input  wire  [$clog2(PACKET_COUNT+2)-1:0]    base,
	output trsw_pkg::scan_stat_t                 stat,
	output logic [$clog2(PACKET_COUNT+2)-1:0]    ack
);
	import trsw_pkg::*;

	localparam int AW = $clog2(PACKET_COUNT);
	localparam int PW = $clog2(PACKET_COUNT+2);

	logic          map_mem_q [0:PACKET_COUNT-1];
	logic          rd_q;
	logic          clear_q;
	logic [AW-1:0] clr_cnt_q;
	logic          scanning_q;
	logic [PW-1:0] ptr_q;
	logic          fwd_q;

	logic [PW-1:0] ptr_inc;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_bit;
	logic          bit_set;

	assign ptr_inc = ptr_q + PW'(1);

	// The first read of a scan goes to the base; later reads run one ahead.
	assign rd_addr = start ? base[AW-1:0] : ptr_inc[AW-1:0];

	// The clearing pass owns the write port until it ends.
	assign wr_en   = clear_q || start;
	assign wr_addr = clear_q ? clr_cnt_q : mark_addr;
	assign wr_bit  = !clear_q;

	// A bit counts as set when read as set or marked in the scan's first cycle.
	assign bit_set = (ptr_q < PW'(PACKET_COUNT)) && (rd_q || fwd_q);

	assign stat.clearing = clear_q;
	assign stat.done     = scanning_q && !bit_set;
	assign ack           = ptr_q;

	// Bitmap storage with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem_q[wr_addr] <= wr_bit;
		end
		rd_q <= map_mem_q[rd_addr];
	end

	// Clearing pass after reset, then the scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_cnt_q  <= '0;
			scanning_q <= 1'b0;
			ptr_q      <= '0;
			fwd_q      <= 1'b0;
		end else begin
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(PACKET_COUNT-1)) begin
					clear_q <= 1'b0;
				end
			end
			if (start) begin
				scanning_q <= 1'b1;
				ptr_q      <= base;
				fwd_q      <= (mark_addr == base[AW-1:0]);
			end else if (scanning_q) begin
				fwd_q <= 1'b0;
				if (bit_set) begin
					ptr_q <= ptr_inc;
				end else begin
					scanning_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

### design/tcp_reno_sender_window_model_top.sv
`default_nettype none

// TCP Reno / NewReno sender window model.
// Input channel: one beat per transmission; lost says whether the packet the
// block sent on that beat was dropped. Output channel: one result beat per
// input beat, in order, giving the packet sent, the cumulative ack, the event,
// the window and threshold after the step, the next packet and a sent count.
// The APB port sets the initial window, initial threshold and variant; writing
// either of the first two also loads the working value at once.
// A lost packet or a beat after the transfer ended is decided in the accepting
// cycle: the result is registered at the accepting edge and the next beat is
// taken right away. A delivered packet starts a scan: the ack pointer walks
// from the old cumulative ack to the new one, one bitmap read per cycle, the
// result is registered when the scan ends, and the next beat can be taken
// after that.
// After reset the received bitmap is cleared one entry a cycle, all PACKET_COUNT
// entries, with in_ready low; APB writes are taken during that time.
// When the receiver stalls, a finished step waits in a hold state and the
// block takes no new beat until the output register is free again.
module tcp_reno_sender_window_model_top #(
	parameter int PACKET_COUNT = trsw_pkg::PACKET_COUNT_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         lost,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  sent_packet,
	output logic [7:0]  cumulative_ack,
	output logic [2:0]  event_res,
	output logic [15:0] window,
	output logic [15:0] threshold,
	output logic [7:0]  next_packet,
	output logic        finished,
	output logic [15:0] sent_total,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import trsw_pkg::*;

	localparam int AW = $clog2(PACKET_COUNT);
	localparam int PW = $clog2(PACKET_COUNT+2);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	state_t        state_q;
	logic          out_valid_q;
	res_t          res_q;
	logic [2:0]    hold_ev_q;
	logic [7:0]    hold_sent_q;
	logic [15:0]   init_win_q;
	logic [15:0]   init_thr_q;
	logic          variant_q;
	logic [15:0]   window_q;
	logic [15:0]   thresh_q;
	logic [7:0]    dup_q;
	logic [PW-1:0] la_q;
	logic [PW-1:0] last_sent_q;
	logic [PW-1:0] nts_q;
	logic [15:0]   trans_q;

	scan_stat_t    scan_stat;
	logic [PW-1:0] scan_ack;
	logic          scan_start;

	logic          in_acc;
	logic          fin;
	logic          out_free;
	logic          commit;
	logic          commit_dec;
	logic          load_out;
	logic          cfg_wr;
	logic [1:0]    cfg_idx;

	logic          dec_lost;
	logic [PW-1:0] dec_ls;
	logic [PW:0]   span;
	logic          span_lt;
	logic [7:0]    dup_inc;
	logic [15:0]   trans_inc;
	logic [15:0]   win_grow;
	logic [15:0]   win_n;
	logic [15:0]   thr_n;
	logic [7:0]    dup_n;
	logic [PW-1:0] la_n;
	logic [PW-1:0] nts_n;
	ev_t           ev_n;
	res_t          res;

	// Handshake and sequencing conditions.
	assign in_ready   = (state_q == S_IDLE) && !scan_stat.clearing;
	assign in_acc     = in_valid && in_ready;
	assign fin        = nts_q > PW'(PACKET_COUNT);
	assign out_free   = !out_valid_q || out_ready;
	assign commit_dec = (in_acc && !fin && lost) || ((state_q == S_SCAN) && scan_stat.done);
	assign commit     = (in_acc && (fin || lost)) || ((state_q == S_SCAN) && scan_stat.done);
	assign load_out   = (commit || (state_q == S_HOLD)) && out_free;
	assign scan_start = in_acc && !fin && !lost;

	// Ack scanner over the received bitmap.
	trsw_ackscan #(
		.PACKET_COUNT(PACKET_COUNT)
	) u_ackscan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.mark_addr(AW'(nts_q - PW'(1))),
		.base     (la_q),
		.stat     (scan_stat),
		.ack      (scan_ack)
	);

	// Step inputs: a lost packet decides in the accepting cycle.
	assign dec_lost  = (state_q == S_IDLE) && lost;
	assign dec_ls    = (state_q == S_IDLE) ? nts_q : last_sent_q;
	assign span      = {1'b0, dec_ls} - {1'b0, la_q};
	assign span_lt   = span[PW] || (16'(span[PW-1:0]) < window_q);
	assign dup_inc   = (dup_q == 8'hFF) ? dup_q : dup_q + 8'd1;
	assign trans_inc = (trans_q == 16'hFFFF) ? trans_q : trans_q + 16'd1;

	// Window growth: double below threshold, else add one, both saturating.
	always_comb begin
		if (window_q < thresh_q) begin
			win_grow = window_q[15] ? 16'hFFFF : {window_q[14:0], 1'b0};
		end else if (window_q != 16'hFFFF) begin
			win_grow = window_q + 16'd1;
		end else begin
			win_grow = window_q;
		end
	end

	// Step decision: new ack, fast recovery, in-order send or timeout.
	always_comb begin
		logic take_span;
		win_n     = window_q;
		thr_n     = thresh_q;
		dup_n     = dup_q;
		la_n      = la_q;
		nts_n     = nts_q;
		ev_n      = EV_CONTINUE;
		take_span = 1'b1;
		if (!dec_lost) begin
			if (scan_ack != la_q) begin
				dup_n     = 8'd0;
				la_n      = scan_ack;
				ev_n      = (window_q < thresh_q) ? EV_SLOW_START : EV_AVOIDANCE;
				win_n     = win_grow;
				nts_n     = scan_ack + PW'(1);
				take_span = 1'b0;
			end else begin
				dup_n = dup_inc;
				if (dup_inc == 8'd2) begin
					if (variant_q == VARIANT_RENO) begin
						win_n = {1'b0, window_q[15:1]};
						thr_n = {1'b0, window_q[15:1]};
					end
					nts_n     = la_q + PW'(1);
					ev_n      = EV_FAST_RECOVERY;
					take_span = 1'b0;
				end
			end
		end
		if (take_span) begin
			if (span_lt) begin
				nts_n = dec_ls + PW'(1);
				ev_n  = EV_CONTINUE;
			end else begin
				thr_n = {1'b0, window_q[15:1]};
				win_n = 16'd1;
				nts_n = la_q + PW'(1);
				ev_n  = EV_TIMEOUT;
			end
		end
	end

	// Result beat: fresh decision, finished report or held step.
	always_comb begin
		if (commit_dec) begin
			res.sent_packet    = 8'(dec_ls);
			res.cumulative_ack = 8'(la_n);
			res.event_res      = ev_n;
			res.window         = win_n;
			res.threshold      = thr_n;
			res.next_packet    = 8'(nts_n);
			res.finished       = nts_n > PW'(PACKET_COUNT);
			res.sent_total     = (state_q == S_IDLE) ? trans_inc : trans_q;
		end else begin
			res.sent_packet    = (state_q == S_HOLD) ? hold_sent_q : 8'd0;
			res.cumulative_ack = 8'(la_q);
			res.event_res      = (state_q == S_HOLD) ? hold_ev_q : EV_FINISHED;
			res.window         = window_q;
			res.threshold      = thresh_q;
			res.next_packet    = 8'(nts_q);
			res.finished       = fin;
			res.sent_total     = trans_q;
		end
	end

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_INIT_WINDOW:    prdata = {16'd0, init_win_q};
			REG_INIT_THRESHOLD: prdata = {16'd0, init_thr_q};
			REG_VARIANT:        prdata = {31'd0, variant_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Sequencer, sender state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			hold_ev_q   <= EV_CONTINUE;
			hold_sent_q <= 8'd0;
			init_win_q  <= INIT_WINDOW_RST;
			init_thr_q  <= INIT_THRESHOLD_RST;
			variant_q   <= VARIANT_RST;
			window_q    <= INIT_WINDOW_RST;
			thresh_q    <= INIT_THRESHOLD_RST;
			dup_q       <= 8'd0;
			la_q        <= '0;
			last_sent_q <= '0;
			nts_q       <= PW'(1);
			trans_q     <= 16'd0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				res_q       <= res;
			end
			if (in_acc && !fin) begin
				last_sent_q <= nts_q;
				trans_q     <= trans_inc;
			end
			if (commit_dec) begin
				window_q <= win_n;
				thresh_q <= thr_n;
				dup_q    <= dup_n;
				la_q     <= la_n;
				nts_q    <= nts_n;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && !commit) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_stat.done) begin
						state_q <= S_IDLE;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit && !out_free) begin
				state_q     <= S_HOLD;
				hold_ev_q   <= res.event_res;
				hold_sent_q <= res.sent_packet;
			end
			if (cfg_wr) begin
				case (cfg_idx)
					REG_INIT_WINDOW: begin
						init_win_q <= pwdata[15:0];
						window_q   <= pwdata[15:0];
					end
					REG_INIT_THRESHOLD: begin
						init_thr_q <= pwdata[15:0];
						thresh_q   <= pwdata[15:0];
					end
					REG_VARIANT: begin
						variant_q <= pwdata[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign sent_packet    = res_q.sent_packet;
	assign cumulative_ack = res_q.cumulative_ack;
	assign event_res      = res_q.event_res;
	assign window         = res_q.window;
	assign threshold      = res_q.threshold;
	assign next_packet    = res_q.next_packet;
	assign finished       = res_q.finished;
	assign sent_total     = res_q.sent_total;

endmodule

`default_nettype wire

### design/trsw_checker.sv
`default_nettype none

`include "tcp_reno_sender_window_model_top_defines.svh"

module trsw_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [7:0]  sent_packet,
	input wire [7:0]  cumulative_ack,
	input wire [2:0]  event_res,
	input wire [15:0] window,
	input wire [7:0]  next_packet,
	input wire        finished
);
	import trsw_pkg::*;

	logic new_ack;

	assign new_ack = out_valid && ((event_res == EV_SLOW_START) || (event_res == EV_AVOIDANCE));

	// A stalled result beat stays valid and keeps its window and sent packet.
	`TRSW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(window) && $stable(sent_packet), "result beat changed while stalled")

	// A step after the transfer sends nothing and reports the end.
	`TRSW_ASSERT_IMP(a_fin_report, out_valid && (event_res == EV_FINISHED), (sent_packet == 8'd0) && finished, "finished step reported a send")

	// A timeout collapses the window to one packet.
	`TRSW_ASSERT_IMP(a_timeout_win, out_valid && (event_res == EV_TIMEOUT), window == 16'd1, "timeout left window above one")

	// A new ack resumes right after the acked packets.
	`TRSW_ASSERT_IMP(a_ack_next, new_ack, next_packet == cumulative_ack + 8'd1, "new ack did not resume after the ack")

endmodule

bind tcp_reno_sender_window_model_top trsw_checker u_trsw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.sent_packet   (sent_packet),
	.cumulative_ack(cumulative_ack),
	.event_res     (event_res),
	.window        (window),
	.next_packet   (next_packet),
	.finished      (finished)
);

`default_nettype wire

### tb/tcp_reno_sender_window_model_top_tb.sv
`timescale 1ns / 100ps

module tcp_reno_sender_window_model_top_tb;
	import trsw_pkg::*;

	localparam int PKTS = PACKET_COUNT_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	// Address just past the last register; writes there must change nothing.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	// One row of the directed table: either a register write or an input beat.
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [15:0] value;
		logic        lost;
		logic        literal;
		res_t        fixed_res;
	} dir_row_t;

	// One random phase: register settings and loss odds for the hole and the rest.
	typedef struct packed {
		logic [15:0] win;
		logic [15:0] thr;
		logic        variant;
		logic [15:0] beats;
		logic [7:0]  hole_loss;
		logic [7:0]  other_loss;
	} phase_t;

	localparam dir_row_t DIR_TAB [28] = '{
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b1,
			'{8'd1, 8'd1, EV_SLOW_START, 16'd8, 16'd16, 8'd2, 1'b0, 16'd1}},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b1,
			'{8'd2, 8'd1, EV_CONTINUE, 16'd8, 16'd16, 8'd3, 1'b0, 16'd2}},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_CFG, REG_VARIANT, 16'(VARIANT_NEWRENO), 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_INIT_WINDOW, 16'd16, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_INIT_WINDOW, 16'd65535, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_INIT_THRESHOLD, 16'd65535, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_INIT_WINDOW, 16'd40000, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_INIT_WINDOW, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_INIT_THRESHOLD, 16'd8, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b1, 1'b0, '0},
		'{ROW_CFG, REG_UNUSED, 16'hffff, 1'b0, 1'b0, '0},
		'{ROW_BEAT, 2'd0, 16'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, REG_VARIANT, 16'(VARIANT_RENO), 1'b0, 1'b0, '0}
	};

	// Small windows first so the transfer lives long; the wide windows come last
	// and run the transfer to its end.
	localparam phase_t PHASES [7] = '{
		'{16'd2, 16'd8, VARIANT_RENO, 16'd220, 8'd92, 8'd50},
		'{16'd0, 16'd0, VARIANT_NEWRENO, 16'd180, 8'd92, 8'd50},
		'{16'd8, 16'd2, VARIANT_NEWRENO, 16'd220, 8'd92, 8'd50},
		'{16'd3, 16'd12, VARIANT_RENO, 16'd220, 8'd92, 8'd50},
		'{16'd1, 16'd65535, VARIANT_NEWRENO, 16'd200, 8'd92, 8'd50},
		'{16'd65535, 16'd65535, VARIANT_RENO, 16'd150, 8'd40, 8'd30},
		'{16'd40000, 16'd65535, VARIANT_NEWRENO, 16'd240, 8'd40, 8'd30}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        lost = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  sent_packet;
	logic [7:0]  cumulative_ack;
	logic [2:0]  event_res;
	logic [15:0] window;
	logic [15:0] threshold;
	logic [7:0]  next_packet;
	logic        finished;
	logic [15:0] sent_total;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Sender state as the checker sees it.
	bit [PKTS-1:0] rx_map = '0;
	int win_now = INIT_WINDOW_RST;
	int thr_now = INIT_THRESHOLD_RST;
	int dup_cnt = 0;
	int acked = 0;
	int last_tx = 0;
	int next_tx = 1;
	int tx_count = 0;
	logic [15:0] cfg_win = INIT_WINDOW_RST;
	logic [15:0] cfg_thr = INIT_THRESHOLD_RST;
	logic        cfg_var = VARIANT_RST;

	res_t awaited_results [$];
	int fail_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	tcp_reno_sender_window_model_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.lost          (lost),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sent_packet   (sent_packet),
		.cumulative_ack(cumulative_ack),
		.event_res     (event_res),
		.window        (window),
		.threshold     (threshold),
		.next_packet   (next_packet),
		.finished      (finished),
		.sent_total    (sent_total),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	// One transmission of the sender; returns the result it reports.
	function automatic res_t sender_step(input logic drop);
		res_t r;
		int pkt;
		int ack_now;
		int span;
		ev_t ev;
		bit settled;
		pkt = 0;
		ack_now = acked;
		ev = EV_CONTINUE;
		settled = 1'b0;
		if (next_tx > PKTS || next_tx == 0) begin
			ev = EV_FINISHED;
		end else begin
			pkt = next_tx;
			last_tx = pkt;
			if (tx_count < 65535)
				tx_count++;
			if (!drop) begin
				rx_map[pkt - 1] = 1'b1;
				ack_now = 0;
				while (ack_now < PKTS && rx_map[ack_now])
					ack_now++;
				if (ack_now == acked) begin
					// Duplicate ack; the second one starts fast recovery.
					if (dup_cnt < 255)
						dup_cnt++;
					if (dup_cnt == 2) begin
						if (cfg_var == VARIANT_RENO) begin
							win_now = win_now / 2;
							thr_now = win_now;
						end
						next_tx = acked + 1;
						ev = EV_FAST_RECOVERY;
						settled = 1'b1;
					end
				end else begin
					// New ack: slow start doubles, avoidance adds one.
					dup_cnt = 0;
					acked = ack_now;
					ev = (win_now < thr_now) ? EV_SLOW_START : EV_AVOIDANCE;
					if (win_now < thr_now) begin
						win_now = win_now * 2;
						if (win_now > 65535)
							win_now = 65535;
					end else if (win_now < 65535) begin
						win_now++;
					end
					next_tx = acked + 1;
					settled = 1'b1;
				end
			end
			if (!settled) begin
				span = last_tx - acked;
				if (span < win_now) begin
					next_tx = last_tx + 1;
					ev = EV_CONTINUE;
				end else begin
					thr_now = win_now / 2;
					win_now = 1;
					next_tx = acked + 1;
					ev = EV_TIMEOUT;
				end
			end
		end
		r.sent_packet = pkt[7:0];
		r.cumulative_ack = ack_now[7:0];
		r.event_res = ev;
		r.window = win_now[15:0];
		r.threshold = thr_now[15:0];
		r.next_packet = next_tx[7:0];
		r.finished = (next_tx > PKTS);
		r.sent_total = tx_count[15:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Lower valid and wait at falling edges until every result beat is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Entered at a falling edge; leaves at the falling edge after acceptance.
	task automatic send_beat(input logic drop, input logic literal, input res_t fixed);
		int gap;
		res_t r;
		gap = (idle_on && $urandom_range(0, 99) < 25) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		lost <= drop;
		do
			@(posedge clk);
		while (!in_ready);
		r = sender_step(drop);
		awaited_results.push_back(literal ? fixed : r);
		@(negedge clk);
	endtask

	// APB write with random upper data bits, then a read back of the register unless it is the unused address.
	task automatic write_config(input logic [1:0] idx, input logic [15:0] value);
		logic [31:0] word;
		logic [31:0] want;
		drain_results();
		word = $urandom;
		if (idx == REG_VARIANT)
			word[0] = value[0];
		else
			word[15:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_INIT_WINDOW: begin
				cfg_win = word[15:0];
				win_now = word[15:0];
			end
			REG_INIT_THRESHOLD: begin
				cfg_thr = word[15:0];
				thr_now = word[15:0];
			end
			REG_VARIANT: begin
				cfg_var = word[0];
			end
			default: begin
			end
		endcase
		if (idx != REG_UNUSED) begin
			@(negedge clk);
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			do
				@(posedge clk);
			while (!pready);
			if (idx == REG_INIT_WINDOW)
				want = {16'd0, cfg_win};
			else if (idx == REG_INIT_THRESHOLD)
				want = {16'd0, cfg_thr};
			else
				want = {31'd0, cfg_var};
			if (prdata !== want) begin
				$error("prdata at index %0d: expected %0h, actual %0h", idx, want, prdata);
				fail_count++;
			end
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver side: random stalls of random length; no new stall starts while idling is off.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			stall_left = idle_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with no expectation: sent_packet %0d", sent_packet);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("sent_packet", want.sent_packet, sent_packet);
				check_field("cumulative_ack", want.cumulative_ack, cumulative_ack);
				check_field("event_res", want.event_res, event_res);
				check_field("window", want.window, window);
				check_field("threshold", want.threshold, threshold);
				check_field("next_packet", want.next_packet, next_packet);
				check_field("finished", want.finished, finished);
				check_field("sent_total", want.sent_total, sent_total);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tcp_reno_sender_window_model_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int k;
		int n;
		logic drop;
		phase_t ph;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows.
		for (k = 0; k < $size(DIR_TAB); k++) begin
			if (DIR_TAB[k].kind == ROW_CFG)
				write_config(DIR_TAB[k].idx, DIR_TAB[k].value);
			else
				send_beat(DIR_TAB[k].lost, DIR_TAB[k].literal, DIR_TAB[k].fixed_res);
		end

		// Random phases. The hole at the cumulative ack is lost more often than
		// the rest, which keeps duplicates, recoveries and timeouts coming.
		for (k = 0; k < $size(PHASES); k++) begin
			ph = PHASES[k];
			write_config(REG_INIT_WINDOW, ph.win);
			write_config(REG_INIT_THRESHOLD, ph.thr);
			write_config(REG_VARIANT, 16'(ph.variant));
			idle_on = (k != 2);
			for (n = 0; n < ph.beats; n++) begin
				if (next_tx == acked + 1)
					drop = ($urandom_range(0, 99) < ph.hole_loss);
				else
					drop = ($urandom_range(0, 99) < ph.other_loss);
				if ($urandom_range(0, 199) == 0)
					drain_results();
				if ($urandom_range(0, 99) < 2)
					idle_on = !idle_on;
				send_beat(drop, 1'b0, '0);
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("tcp_reno_sender_window_model_top regression: pass");
		else
			$display("tcp_reno_sender_window_model_top regression: fail");
		$finish;
	end

endmodule
